>>> design/b93_pkg.sv
// b93_pkg: constants, types and the digit weight table for the base-93 word decoder
// no dependencies; imported by every module of the block

package b93_pkg;

   // group and word geometry
   localparam int DIGITS_PER_GROUP    = 5;
   localparam int BYTES_PER_WORD      = 4;
   localparam int WORD_W              = 32;
   localparam int CHAR_W              = 8;
   localparam int CNT_W               = 3;
   localparam int BYTE_IDX_W          = $clog2(BYTES_PER_WORD);
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // character codes
   localparam logic [CHAR_W-1:0] DIGIT_OFFSET = CHAR_W'(33);
   localparam logic [CHAR_W-1:0] SPACE_CHAR   = CHAR_W'(32);

   // queue fill status handed from the queue to both sides
   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   // power of 93 for a digit position
   function automatic logic [WORD_W-1:0] digit_weight(input logic [CNT_W-1:0] pos);
      logic [WORD_W-1:0] w;
      unique case (pos)
         3'd0: w = 32'd1;
         3'd1: w = 32'd93;
         3'd2: w = 32'd8649;
         3'd3: w = 32'd804357;
         3'd4: w = 32'd74805201;
         default: w = 32'd1;
      endcase
      return w;
   endfunction

endpackage

>>> design/b93_if.sv
// b93_if: valid/ready channel interfaces for character input and byte output
// depends on b93_pkg for field widths

interface b93_req_if
   import b93_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_in;
   logic              stream_end;

   modport source (output valid, output char_in, output stream_end, input ready);
   modport sink   (input valid, input char_in, input stream_end, output ready);
endinterface

interface b93_rsp_if
   import b93_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] byte_out;
   logic              word_last;

   modport source (output valid, output byte_out, output word_last, input ready);
   modport sink   (input valid, input byte_out, input word_last, output ready);
endinterface

>>> design/base93_word_decoder_top.sv
// base93_word_decoder_top: a group-closing character pushes its word into the queue, and
// the serializer loads it from there before its first byte goes out on rsp; rsp_valid stays
// high for 4 consecutive byte transfers. throughput: one character per cycle while the
// word queue has room; the byte serializer sends one byte per cycle if rsp_ready is high.
// reset is synchronous, active high: clears digit count, accumulator, queue and rsp_valid.
// depends on b93_pkg, b93_if, b93_front, b93_queue, b93_back

module base93_word_decoder_top
   import b93_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   b93_req_if.sink    req_if,
   b93_rsp_if.source  rsp_if
);

   q_status_type      q_status;
   logic              push;
   logic [WORD_W-1:0] push_word;
   logic              pop;
   logic [WORD_W-1:0] head_word;

   // digit accumulation
   b93_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_if.valid),
      .in_ready   (req_if.ready),
      .char_in    (req_if.char_in),
      .stream_end (req_if.stream_end),
      .q_status   (q_status),
      .push       (push),
      .push_word  (push_word)
   );

   // word queue
   b93_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (push_word),
      .pop       (pop),
      .head_word (head_word),
      .status    (q_status)
   );

   // byte serializer
   b93_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .head_word (head_word),
      .pop       (pop),
      .out_valid (rsp_if.valid),
      .out_ready (rsp_if.ready),
      .byte_out  (rsp_if.byte_out),
      .word_last (rsp_if.word_last)
   );

endmodule

>>> design/b93_front.sv
// b93_front: accepts characters, accumulates base-93 digits and closes groups
// depends on b93_pkg; pushes finished words into b93_queue

module b93_front
   import b93_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [CHAR_W-1:0] char_in,
   input  logic              stream_end,
   input  q_status_type      q_status,
   output logic              push,
   output logic [WORD_W-1:0] push_word
);

   logic [WORD_W-1:0] accum_ff, accum_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              take;
   logic              is_space;
   logic              group_full;
   logic [CHAR_W:0]   diff;
   logic [WORD_W-1:0] diff_ext;
   logic [CNT_W-1:0]  wsel;
   logic [WORD_W-1:0] product;

   // accept whenever the queue can hold a word
   assign in_ready = !q_status.full;
   assign take     = in_valid && in_ready;

   // digit value as signed difference, weighted by its position
   assign is_space   = (char_in == SPACE_CHAR);
   assign group_full = (cnt_ff == CNT_W'(DIGITS_PER_GROUP));
   assign diff       = {1'b0, char_in} - {1'b0, DIGIT_OFFSET};
   assign diff_ext   = {{(WORD_W-CHAR_W-1){diff[CHAR_W]}}, diff};
   assign wsel       = group_full ? '0 : cnt_ff;
   assign product    = diff_ext * digit_weight(wsel);

   // group close decision and next accumulator
   always_comb begin
      accum_in = accum_ff;
      cnt_in   = cnt_ff;
      push     = 1'b0;
      if (take) begin
         priority if (stream_end) begin
            push     = (cnt_ff != '0);
            accum_in = '0;
            cnt_in   = '0;
         end else if (is_space) begin
            push     = 1'b1;
            accum_in = '0;
            cnt_in   = '0;
         end else if (group_full) begin
            push     = 1'b1;
            accum_in = product;
            cnt_in   = CNT_W'(1);
         end else begin
            accum_in = accum_ff + product;
            cnt_in   = cnt_ff + CNT_W'(1);
         end
      end
   end

   assign push_word = accum_ff;

   // group state
   always_ff @(posedge clock) begin
      if (reset) begin
         accum_ff <= '0;
         cnt_ff   <= '0;
      end else begin
         accum_ff <= accum_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

>>> design/b93_queue.sv
// b93_queue: small word queue between the digit front and the byte back
// depends on b93_pkg; depth set by the DEPTH parameter

module b93_queue
   import b93_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [WORD_W-1:0] push_word,
   input  logic              pop,
   output logic [WORD_W-1:0] head_word,
   output q_status_type      status
);

   localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_W = $clog2(DEPTH + 1);

   logic [WORD_W-1:0]  mem [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   assign status.full  = (count_ff == COUNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign head_word    = mem[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      unique case ({push, pop})
         2'b10:   count_in = count_ff + COUNT_W'(1);
         2'b01:   count_in = count_ff - COUNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_word;
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> design/b93_back.sv
// b93_back: takes words from the queue and sends them as four bytes, low byte first
// depends on b93_pkg; output payload is selected from registers

module b93_back
   import b93_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  q_status_type      q_status,
   input  logic [WORD_W-1:0] head_word,
   output logic              pop,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [CHAR_W-1:0] byte_out,
   output logic              word_last
);

   logic [WORD_W-1:0]     word_ff, word_in;
   logic [BYTE_IDX_W-1:0] idx_ff, idx_in;
   logic                  busy_ff, busy_in;
   logic                  transfer;
   logic                  at_last;
   logic                  load;

   assign transfer = busy_ff && out_ready;
   assign at_last  = (idx_ff == BYTE_IDX_W'(BYTES_PER_WORD - 1));
   // fetch a new word when idle or as the last byte leaves
   assign load     = !q_status.empty && (!busy_ff || (transfer && at_last));
   assign pop      = load;

   // byte sequencing
   always_comb begin
      word_in = word_ff;
      idx_in  = idx_ff;
      busy_in = busy_ff;
      if (load) begin
         word_in = head_word;
         idx_in  = '0;
         busy_in = 1'b1;
      end else if (transfer) begin
         if (at_last) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + BYTE_IDX_W'(1);
         end
      end
   end

   // byte select
   always_comb begin
      unique case (idx_ff)
         2'd0:    byte_out = word_ff[7:0];
         2'd1:    byte_out = word_ff[15:8];
         2'd2:    byte_out = word_ff[23:16];
         default: byte_out = word_ff[31:24];
      endcase
   end

   assign out_valid = busy_ff;
   assign word_last = at_last;

   // payload
   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff  <= '0;
         busy_ff <= 1'b0;
      end else begin
         idx_ff  <= idx_in;
         busy_ff <= busy_in;
      end
   end

endmodule

>>> design/b93_checker.sv
// b93_checker: port-level assertions for base93_word_decoder_top, attached by bind
// depends on b93_pkg for widths

module b93_checker
   import b93_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [CHAR_W-1:0] byte_out,
   input logic              word_last
);

   logic [BYTE_IDX_W-1:0] seen_ff, seen_in;
   logic                  rsp_xfer;

   assign rsp_xfer = rsp_valid && rsp_ready;

   // bytes of the current word already transferred
   always_comb begin
      seen_in = seen_ff;
      if (rsp_xfer) begin
         seen_in = seen_ff + BYTE_IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
      end else begin
         seen_ff <= seen_in;
      end
   end

   // a stalled byte stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   // a stalled byte keeps its value
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(byte_out) && $stable(word_last))
      else $error("rsp payload changed while stalled");

   // every fourth byte transfer closes a word
   a_last_place: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer |-> (word_last == (seen_ff == BYTE_IDX_W'(BYTES_PER_WORD - 1))))
      else $error("word_last out of place");

   // nothing is offered or taken right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // input is ready right after reset since the queue starts empty
   a_reset_ready: assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("req_ready low after reset");

endmodule

bind base93_word_decoder_top b93_checker u_b93_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_if.ready),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .byte_out  (rsp_if.byte_out),
   .word_last (rsp_if.word_last)
);
